### sv/ttdl_pkg.sv
`default_nettype none

package ttdl_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MASS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_MAX = 3'd4;

  // bit-serial divider geometry
  localparam int DIV_STEPS = 8;
  localparam int QUO_W     = DIV_STEPS;
  localparam int DEN_W     = 14;
  localparam int NUM_W     = DEN_W + QUO_W - 1;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } ttdl_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } ttdl_div_rsp_t;

endpackage

`default_nettype wire

### sv/ttdl_if.sv
`default_nettype none

interface ttdl_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [7:0]  target_x;
  logic signed [7:0]  target_y;
  logic        [13:0] target_mass;

  modport source (
    output valid, restart, target_x, target_y, target_mass,
    input  ready
  );
  modport sink (
    input  valid, restart, target_x, target_y, target_mass,
    output ready
  );
endinterface

interface ttdl_out_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] power_left;
  logic signed [9:0] power_right;
  logic        [7:0] pwm_left;
  logic        [7:0] pwm_right;
  logic signed [9:0] yaw_out;
  logic signed [9:0] speed_out;

  modport source (
    output valid, power_left, power_right, pwm_left, pwm_right, yaw_out, speed_out,
    input  ready
  );
  modport sink (
    input  valid, power_left, power_right, pwm_left, pwm_right, yaw_out, speed_out,
    output ready
  );
endinterface

`default_nettype wire

### sv/target_tracking_drive_loop_top.sv
// Target-tracking drive loop.
// Input channel in_i carries one vision word per camera frame: restart, target_x,
// target_y and target_mass. Output channel out_o returns one word per input word:
// soft-limited left/right powers, their PWM bytes and the stored yaw and speed.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while idle; the block does not enforce it. Writes to unused indexes are
// ignored. Each input word is accepted in idle and makes five passes through a
// single bit-serial divider: x, mass and y deviations, then (after leaky
// accumulation and soft limiting) left and right PWM; a load of the output
// register follows. in_i.ready is high only between words.
// A finished word waits in the output register; the next input word is accepted
// and processed meanwhile, and a stalled receiver holds the block only when a
// second result is ready before the first is taken.
// Reset clears stored yaw and speed, empties the output register and restores the
// configuration defaults (zero points 0/0/5000, PWM range 0..255).
`default_nettype none

module target_tracking_drive_loop_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  ttdl_in_if.sink                             in_i,
  ttdl_out_if.source                          out_o,
  input  wire                                 cfg_we_i,
  input  wire  [ttdl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [ttdl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import ttdl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DX   = 4'd1;
  localparam logic [3:0] S_DM   = 4'd2;
  localparam logic [3:0] S_DY   = 4'd3;
  localparam logic [3:0] S_MIX1 = 4'd4;
  localparam logic [3:0] S_MIX2 = 4'd5;
  localparam logic [3:0] S_PL   = 4'd6;
  localparam logic [3:0] S_PR   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // configuration
  logic signed [7:0]  zero_x_q;
  logic signed [7:0]  zero_y_q;
  logic        [13:0] zero_mass_q;
  logic        [7:0]  pmin_q;
  logic        [7:0]  pmax_q;

  // control
  logic [3:0] state_q, state_d;
  logic       run_q, run_d;
  logic       is_div;
  logic       in_acc;
  logic       out_load;
  logic       out_valid_q;

  // item data
  logic signed [7:0]  tx_q;
  logic signed [7:0]  ty_q;
  logic        [13:0] tm_q;
  logic signed [7:0]  dev_x_q;
  logic signed [7:0]  dev_m_q;
  logic signed [7:0]  dev_y_q;
  logic signed [9:0]  last_yaw_q;
  logic signed [9:0]  last_speed_q;
  logic signed [10:0] pl_q;
  logic signed [10:0] pr_q;
  logic        [7:0]  pwm_l_q;
  logic        [7:0]  pwm_r_q;

  // output register
  logic signed [9:0] o_pl_q, o_pr_q, o_yaw_q, o_speed_q;
  logic        [7:0] o_pwml_q, o_pwmr_q;

  // divider
  ttdl_div_req_t div_req;
  ttdl_div_rsp_t div_rsp;

  ttdl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // deviation setup
  logic signed [15:0] dv_v, dv_z, dv_lo, dv_hi, dv_diff, dv_den;
  logic               dv_gt, dv_lt, dv_sat;
  logic [NUM_W-1:0]   dv_num;
  logic [7:0]         dv_res;

  always_comb begin
    unique case (state_q)
      S_DM: begin
        dv_v  = {2'b00, tm_q};
        dv_z  = {2'b00, zero_mass_q};
        dv_lo = 16'sd0;
        dv_hi = 16'sd10000;
      end
      S_DY: begin
        dv_v  = {{8{ty_q[7]}}, ty_q};
        dv_z  = {{8{zero_y_q[7]}}, zero_y_q};
        dv_lo = -16'sd100;
        dv_hi = 16'sd100;
      end
      default: begin
        dv_v  = {{8{tx_q[7]}}, tx_q};
        dv_z  = {{8{zero_x_q[7]}}, zero_x_q};
        dv_lo = -16'sd100;
        dv_hi = 16'sd100;
      end
    endcase
  end

  assign dv_gt   = (dv_v > dv_z);
  assign dv_lt   = (dv_v < dv_z);
  assign dv_sat  = dv_gt ? (dv_v >= dv_hi) : (dv_v <= dv_lo);
  assign dv_diff = dv_gt ? (dv_v - dv_z) : (dv_z - dv_v);
  assign dv_den  = dv_gt ? (dv_hi - dv_z) : (dv_z - dv_lo);
  assign dv_num  = NUM_W'(dv_diff[DEN_W-1:0]) * NUM_W'(100);

  always_comb begin
    priority if (!dv_gt && !dv_lt) begin
      dv_res = 8'd0;
    end else if (dv_sat) begin
      dv_res = dv_gt ? 8'd100 : 8'(-8'sd100);
    end else begin
      dv_res = dv_gt ? div_rsp.quo : (~div_rsp.quo + 8'd1);
    end
  end

  // pwm setup
  logic signed [10:0] pw_p;
  logic        [10:0] pw_mag;
  logic               pw_zero, pw_big, pw_neg;
  logic signed [8:0]  pw_span;
  logic        [7:0]  pw_aspan;
  logic        [14:0] pw_prod;
  logic        [7:0]  pw_res;

  assign pw_p     = (state_q == S_PR) ? pr_q : pl_q;
  assign pw_mag   = pw_p[10] ? 11'(-pw_p) : pw_p;
  assign pw_zero  = (pw_p == 11'sd0);
  assign pw_big   = (pw_mag > 11'd100);
  assign pw_span  = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign pw_neg   = pw_span[8];
  assign pw_aspan = pw_neg ? 8'(-pw_span) : pw_span[7:0];
  assign pw_prod  = 15'(pw_aspan) * 15'(pw_mag[6:0]);

  always_comb begin
    priority if (pw_zero) begin
      pw_res = 8'd0;
    end else if (pw_big) begin
      pw_res = pmax_q;
    end else if (pw_neg) begin
      pw_res = pmin_q - div_rsp.quo;
    end else begin
      pw_res = pmin_q + div_rsp.quo;
    end
  end

  // divider request
  logic div_start;
  logic pw_sel;

  assign pw_sel        = (state_q == S_PL) || (state_q == S_PR);
  assign div_req.start = div_start;
  assign div_req.num   = pw_sel ? NUM_W'(pw_prod) : dv_num;
  assign div_req.den   = pw_sel ? DEN_W'(100) : dv_den[DEN_W-1:0];

  // leaky accumulation and soft limit
  function automatic logic [9:0] leaky(input logic signed [10:0] p,
                                       input logic signed [9:0] last);
    logic        [9:0]  a;
    logic        [17:0] prod;
    logic signed [6:0]  t;
    logic signed [1:0]  sl;
    logic               same;
    logic signed [11:0] s;
    a    = last[9] ? 10'(-last) : last;
    prod = 18'(a) * 18'd205;
    t    = last[9] ? -$signed({1'b0, prod[16:11]}) : $signed({1'b0, prod[16:11]});
    sl   = last[9] ? -2'sd1 : ((last != 10'sd0) ? 2'sd1 : 2'sd0);
    same = ((p > 0) && (last > 0)) || ((p < 0) && (last < 0)) ||
           ((p == 0) && (last == 0));
    s    = 12'(p) + (same ? (12'(t) + 12'(sl)) : 12'sd0);
    priority if (s > 12'sd511) begin
      return 10'sd511;
    end else if (s < -12'sd512) begin
      return 10'(-12'sd512);
    end else begin
      return s[9:0];
    end
  endfunction

  function automatic logic [10:0] soft_limit(input logic signed [11:0] p);
    logic signed [11:0] t;
    logic signed [11:0] r;
    priority if (p >= 12'sd30) begin
      t = p - 12'sd30;
      r = 12'sd30 + (t >>> 1);
    end else if (p <= -12'sd30) begin
      t = -(p + 12'sd30);
      r = -12'sd30 - (t >>> 1);
    end else begin
      t = 12'sd0;
      r = p;
    end
    return r[10:0];
  endfunction

  logic signed [10:0] b_ext, bterm, speed_pre, yaw_pre;
  logic signed [11:0] pl_raw, pr_raw;

  assign b_ext     = 11'(dev_y_q) - 11'sd20;
  assign bterm     = (dev_y_q >= 8'sd20) ? (b_ext + (b_ext <<< 1)) : 11'sd0;
  assign speed_pre = 11'(dev_m_q) + bterm;
  assign yaw_pre   = 11'(dev_x_q);
  assign pl_raw    = 12'(last_yaw_q) - 12'(last_speed_q);
  assign pr_raw    = -12'(last_speed_q) - 12'(last_yaw_q);

  // sequencer
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign is_div   = (state_q == S_DX) || (state_q == S_DM) || (state_q == S_DY) ||
                    (state_q == S_PL) || (state_q == S_PR);

  always_comb begin
    state_d   = state_q;
    run_d     = run_q;
    div_start = 1'b0;
    if (is_div) begin
      if (!run_q) begin
        div_start = 1'b1;
        run_d     = 1'b1;
      end else if (div_rsp.done) begin
        run_d = 1'b0;
      end
    end
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_DX;
      S_DX:   if (run_q && div_rsp.done) state_d = S_DM;
      S_DM:   if (run_q && div_rsp.done) state_d = S_DY;
      S_DY:   if (run_q && div_rsp.done) state_d = S_MIX1;
      S_MIX1: state_d = S_MIX2;
      S_MIX2: state_d = S_PL;
      S_PL:   if (run_q && div_rsp.done) state_d = S_PR;
      S_PR:   if (run_q && div_rsp.done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      run_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      last_yaw_q   <= '0;
      last_speed_q <= '0;
      zero_x_q     <= '0;
      zero_y_q     <= '0;
      zero_mass_q  <= 14'd5000;
      pmin_q       <= 8'd0;
      pmax_q       <= 8'd255;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && in_i.restart) begin
        last_yaw_q   <= '0;
        last_speed_q <= '0;
      end else if (state_q == S_MIX1) begin
        last_yaw_q   <= leaky(yaw_pre, last_yaw_q);
        last_speed_q <= leaky(speed_pre, last_speed_q);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ZERO_X:    zero_x_q    <= cfg_wdata_i[7:0];
          CFG_ZERO_Y:    zero_y_q    <= cfg_wdata_i[7:0];
          CFG_ZERO_MASS: zero_mass_q <= cfg_wdata_i[13:0];
          CFG_POWER_MIN: pmin_q      <= cfg_wdata_i[7:0];
          CFG_POWER_MAX: pmax_q      <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_q <= in_i.target_x;
      ty_q <= in_i.target_y;
      tm_q <= in_i.target_mass;
    end
    if (run_q && div_rsp.done) begin
      unique case (state_q)
        S_DX:    dev_x_q <= dv_res;
        S_DM:    dev_m_q <= dv_res;
        S_DY:    dev_y_q <= dv_res;
        S_PL:    pwm_l_q <= pw_res;
        S_PR:    pwm_r_q <= pw_res;
        default: ;
      endcase
    end
    if (state_q == S_MIX2) begin
      pl_q <= soft_limit(pl_raw);
      pr_q <= soft_limit(pr_raw);
    end
    if (out_load) begin
      o_pl_q    <= pl_q[9:0];
      o_pr_q    <= pr_q[9:0];
      o_pwml_q  <= pwm_l_q;
      o_pwmr_q  <= pwm_r_q;
      o_yaw_q   <= last_yaw_q;
      o_speed_q <= last_speed_q;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.power_left  = o_pl_q;
  assign out_o.power_right = o_pr_q;
  assign out_o.pwm_left    = o_pwml_q;
  assign out_o.pwm_right   = o_pwmr_q;
  assign out_o.yaw_out     = o_yaw_q;
  assign out_o.speed_out   = o_speed_q;

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_dx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_DX))
    else $error("accepted word did not start x deviation");

  a_done_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (run_q && is_div))
    else $error("divider done outside a divide pass");

  a_restart_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.restart) |=> (last_yaw_q == 10'sd0) && (last_speed_q == 10'sd0))
    else $error("restart did not clear stored yaw and speed");

endmodule

`default_nettype wire

### sv/ttdl_div.sv
`default_nettype none

module ttdl_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ttdl_pkg::ttdl_div_req_t  req_i,
  output ttdl_pkg::ttdl_div_rsp_t  rsp_o
);
  import ttdl_pkg::*;

  logic [NUM_W-1:0] rem_q;
  logic [NUM_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             busy;
  logic             ge;

  assign busy = (cnt_q != '0);
  assign ge   = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        cnt_q <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // one quotient bit per cycle, divisor shifts right
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      dsh_q <= {req_i.den, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy = busy;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ttdl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 80;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic              restart;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic       [13:0] mass;
  } vision_word_t;

  typedef struct packed {
    logic signed [9:0] power_l;
    logic signed [9:0] power_r;
    logic        [7:0] duty_l;
    logic        [7:0] duty_r;
    logic signed [9:0] yaw;
    logic signed [9:0] speed;
  } drive_word_t;

  class drive_scoreboard;
    int zero_x, zero_y, zero_mass, duty_lo, duty_hi;
    int held_yaw, held_speed;
    drive_word_t drive_due[$];
    int words_in, words_out, fails, restarts, backoffs, duty_sat;

    function new();
      zero_x = 0;
      zero_y = 0;
      zero_mass = 5000;
      duty_lo = 0;
      duty_hi = 255;
      held_yaw = 0;
      held_speed = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ZERO_X:    zero_x = int'($signed(data[7:0]));
        CFG_ZERO_Y:    zero_y = int'($signed(data[7:0]));
        CFG_ZERO_MASS: zero_mass = int'(data);
        CFG_POWER_MIN: duty_lo = int'(data[7:0]);
        CFG_POWER_MAX: duty_hi = int'(data[7:0]);
        default: ;
      endcase
    endfunction

    function int sign_of(int v);
      return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    // percent offset from the zero point, saturating at the range ends
    function int pct_offset(int v, int lo, int z, int hi);
      if (v > z) begin
        if (v >= hi) return 100;
        return (100 * (v - z)) / (hi - z);
      end
      if (v < z) begin
        if (v <= lo) return -100;
        return -((100 * (z - v)) / (z - lo));
      end
      return 0;
    endfunction

    function int leak_in(int p, int held);
      if (sign_of(p) == sign_of(held)) p += (held * 10) / 100 + sign_of(held);
      if (p > 511) p = 511;
      if (p < -512) p = -512;
      return p;
    endfunction

    function int soften(int p);
      if (p >= 30) return 30 + (p - 30) / 2;
      if (p <= -30) return -30 + (p + 30) / 2;
      return p;
    endfunction

    function logic [7:0] duty_of(int p);
      int mag, v;
      if (p == 0) return 8'd0;
      mag = (p < 0) ? -p : p;
      if (mag > 100) v = duty_hi;
      else v = duty_lo + ((duty_hi - duty_lo) * mag) / 100;
      return 8'(v);
    endfunction

    function void add_vision(vision_word_t w);
      int yaw, spd, back, pl, pr;
      drive_word_t d;
      if (w.restart) begin
        held_yaw = 0;
        held_speed = 0;
        restarts++;
      end
      yaw = leak_in(pct_offset(int'(w.x), -100, zero_x, 100), held_yaw);
      spd = pct_offset(int'(w.mass), 0, zero_mass, 10000);
      back = pct_offset(int'(w.y), -100, zero_y, 100);
      if (back >= 20) begin
        spd += (back - 20) * 3;
        backoffs++;
      end
      spd = leak_in(spd, held_speed);
      held_yaw = yaw;
      held_speed = spd;
      pl = soften(yaw - spd);
      pr = soften(-spd - yaw);
      if (pl > 100 || pl < -100 || pr > 100 || pr < -100) duty_sat++;
      d.power_l = 10'(pl);
      d.power_r = 10'(pr);
      d.duty_l = duty_of(pl);
      d.duty_r = duty_of(pr);
      d.yaw = 10'(yaw);
      d.speed = 10'(spd);
      drive_due.push_back(d);
      words_in++;
    endfunction

    function void check_drive(drive_word_t got);
      drive_word_t exp;
      words_out++;
      if (drive_due.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected drive word: pl=%0d pr=%0d", got.power_l, got.power_r);
        return;
      end
      exp = drive_due.pop_front();
      if (got.power_l !== exp.power_l || got.power_r !== exp.power_r ||
          got.duty_l !== exp.duty_l || got.duty_r !== exp.duty_r ||
          got.yaw !== exp.yaw || got.speed !== exp.speed) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("mismatch at word %0d: exp pl=%0d pr=%0d dl=%0d dr=%0d yaw=%0d spd=%0d",
                   words_out, exp.power_l, exp.power_r, exp.duty_l, exp.duty_r,
                   exp.yaw, exp.speed);
          $display("                 got pl=%0d pr=%0d dl=%0d dr=%0d yaw=%0d spd=%0d",
                   got.power_l, got.power_r, got.duty_l, got.duty_r, got.yaw, got.speed);
        end
      end
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic hold_req = 1'b0;
  int tx_idle_pct = 14;
  int rx_idle_pct = 61;
  int unsigned cycles = 0;
  int cfg_sets = 0;
  int run_left = 0;
  int base_x, base_y, base_mass;

  drive_scoreboard sb;

  ttdl_in_if  in_if ();
  ttdl_out_if out_if ();

  target_tracking_drive_loop_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    drive_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.power_l = out_if.power_left;
      got.power_r = out_if.power_right;
      got.duty_l = out_if.pwm_left;
      got.duty_r = out_if.pwm_right;
      got.yaw = out_if.yaw_out;
      got.speed = out_if.speed_out;
      sb.check_drive(got);
    end
  end

  function automatic int rand_span(int lo, int hi);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // mostly steady tracking runs so the accumulators build up, some noise
  function automatic vision_word_t next_vision();
    vision_word_t w;
    if (run_left == 0) begin
      run_left = $urandom_range(20, 4);
      base_x = rand_span(-100, 100);
      base_y = rand_span(-100, 100);
      base_mass = rand_span(0, 10000);
      w.restart = ($urandom_range(3) == 0);
    end else begin
      w.restart = ($urandom_range(63) == 0);
    end
    run_left--;
    if ($urandom_range(9) == 0) begin
      w.x = 8'($urandom);
      w.y = 8'($urandom);
      w.mass = 14'($urandom);
    end else begin
      w.x = 8'(clip(base_x + int'($urandom_range(20)) - 10, -128, 127));
      w.y = 8'(clip(base_y + int'($urandom_range(20)) - 10, -128, 127));
      w.mass = 14'(clip(base_mass + int'($urandom_range(800)) - 400, 0, 16383));
    end
    return w;
  endfunction

  task automatic send_vision(vision_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= w.restart;
    in_if.target_x <= w.x;
    in_if.target_y <= w.y;
    in_if.target_mass <= w.mass;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.add_vision(w);
  endtask

  task automatic send_fields(bit r, int x, int y, int m);
    vision_word_t w;
    w.restart = r;
    w.x = 8'(x);
    w.y = 8'(y);
    w.mass = 14'(m);
    send_vision(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(int zx, int zy, int zm, int lo, int hi);
    logic [CFG_IDX_W-1:0] idxs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idxs = '{CFG_ZERO_X, CFG_ZERO_Y, CFG_ZERO_MASS, CFG_POWER_MIN, CFG_POWER_MAX};
    vals = '{14'(zx), 14'(zy), 14'(zm), 14'(lo), 14'(hi)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  initial begin
    sb = new();
    in_if.valid <= 1'b0;
    in_if.restart <= 1'b0;
    in_if.target_x <= '0;
    in_if.target_y <= '0;
    in_if.target_mass <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: range ends, beyond-range values, back-off, accumulation
    send_fields(1, 0, 0, 5000);
    send_fields(0, 100, 0, 5000);
    send_fields(0, 127, 0, 5000);
    send_fields(1, -128, 0, 5000);
    send_fields(0, -100, -100, 0);
    send_fields(0, 0, 0, 10000);
    send_fields(0, 0, 127, 16383);
    send_fields(1, 0, 100, 5000);
    send_fields(0, 0, 20, 5000);
    send_fields(0, 0, 25, 4999);
    send_fields(0, -1, 0, 4999);
    send_fields(1, 50, 0, 7500);
    send_fields(0, 50, 0, 7500);
    send_fields(0, 50, 0, 7500);

    // zero points at range ends, inverted pwm range
    drain();
    write_regs(-100, 100, 0, 200, 10);
    send_fields(1, -100, 100, 0);
    send_fields(0, -128, -100, 3);
    send_fields(0, 100, -128, 10000);
    send_fields(0, 1, 127, 16383);
    drain();
    write_regs(100, -100, 10000, 255, 0);
    send_fields(1, 100, -100, 10000);
    send_fields(0, 127, 100, 0);
    send_fields(0, -100, 0, 9999);
    send_fields(0, 99, -99, 16383);

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 14 : ((p < 4) ? 61 : 0);
      rx_idle_pct = (p < 2) ? 61 : ((p < 4) ? 14 : 0);
      drain();
      write_regs(rand_span(-100, 100), rand_span(-100, 100), rand_span(0, 10000),
                 rand_span(0, 255), rand_span(0, 255));
      if (p == 4) hold_req <= 1'b1;
      for (int i = 0; i < 125; i++) begin
        if (p == 5 && i == 60) drain();
        send_vision(next_vision());
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d vision words in, %0d drive words checked over %0d register sets",
             sb.words_in, sb.words_out, cfg_sets);
    $display("restarts %0d, back-off steps %0d, saturated pwm steps %0d, mismatches %0d",
             sb.restarts, sb.backoffs, sb.duty_sat, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
